FILE: rtl/idfe_pkg.sv
// Package for the IMU datagram field extractor: section codes, result kind codes,
// register indexes, queue entry and gain types, and section ordering helpers.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package idfe_pkg;

  // Sections of a normal-mode datagram, in the order they are sent.
  typedef enum logic [3:0] {
    SEC_IDLE       = 4'd0,
    SEC_GYRO       = 4'd1,
    SEC_ACCEL      = 4'd2,
    SEC_INCL       = 4'd3,
    SEC_GYRO_TEMP  = 4'd4,
    SEC_ACCEL_TEMP = 4'd5,
    SEC_INCL_TEMP  = 4'd6,
    SEC_AUX        = 4'd7,
    SEC_COUNTER    = 4'd8,
    SEC_LATENCY    = 4'd9
  } section_t;

  // Result kind codes as seen on the output channel.
  localparam logic [3:0] KIND_GYRO       = 4'd0;
  localparam logic [3:0] KIND_ACCEL      = 4'd1;
  localparam logic [3:0] KIND_INCL       = 4'd2;
  localparam logic [3:0] KIND_GYRO_TEMP  = 4'd3;
  localparam logic [3:0] KIND_ACCEL_TEMP = 4'd4;
  localparam logic [3:0] KIND_INCL_TEMP  = 4'd5;
  localparam logic [3:0] KIND_AUX        = 4'd6;
  localparam logic [3:0] KIND_COUNTER    = 4'd7;
  localparam logic [3:0] KIND_LATENCY    = 4'd8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_MASK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLINE_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_GAIN         = 3'd5;

  // Bits of the include mask.
  localparam int MASK_W     = 5;
  localparam int MASK_GYRO  = 0;
  localparam int MASK_ACCEL = 1;
  localparam int MASK_INCL  = 2;
  localparam int MASK_TEMP  = 3;
  localparam int MASK_AUX   = 4;
  localparam logic [MASK_W-1:0] MASK_RESET = 5'h1F;

  localparam int GAIN_W     = 40;
  localparam int GAIN_SPLIT = 20;
  localparam int RAW_W      = 24;
  localparam int SX_W       = RAW_W + 1;
  localparam int PP_W       = SX_W + GAIN_SPLIT + 1;
  localparam int VALUE_W    = 64;

  // The axis slot that holds the status byte after a sensor section.
  localparam logic [1:0] STATUS_SLOT  = 2'd3;
  localparam logic [1:0] STATUS_BYTES = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [3:0]       kind;
    logic [1:0]       axis;
    logic [RAW_W-1:0] raw;
    logic [1:0]       nbytes;
    logic [7:0]       status;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gyro;
    logic [GAIN_W-1:0] accel;
    logic [GAIN_W-1:0] incline;
    logic [GAIN_W-1:0] temperature;
    logic [GAIN_W-1:0] aux;
  } gains_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic present(section_t s, logic [MASK_W-1:0] m);
    logic r;
    case (s)
      SEC_GYRO:       r = m[MASK_GYRO];
      SEC_ACCEL:      r = m[MASK_ACCEL];
      SEC_INCL:       r = m[MASK_INCL];
      SEC_GYRO_TEMP:  r = m[MASK_TEMP] & m[MASK_GYRO];
      SEC_ACCEL_TEMP: r = m[MASK_TEMP] & m[MASK_ACCEL];
      SEC_INCL_TEMP:  r = m[MASK_TEMP] & m[MASK_INCL];
      SEC_AUX:        r = m[MASK_AUX];
      default:        r = 1'b1;
    endcase
    return r;
  endfunction

  // First included section after s; counter is always there.
  function automatic section_t following(section_t s, logic [MASK_W-1:0] m);
    section_t n;
    logic     found;
    n     = SEC_COUNTER;
    found = 1'b0;
    for (int i = 1; i < 8; i++) begin
      if (!found && (4'(i) > s) && present(section_t'(4'(i)), m)) begin
        n     = section_t'(4'(i));
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/idfe_if.sv
// Channel interfaces of the IMU datagram field extractor: byte input, result
// output and configuration write. Depends on idfe_pkg for field widths.
`default_nettype none

interface idfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface idfe_out_if;
  logic                               valid;
  logic                               ready;
  logic [3:0]                         kind;
  logic [1:0]                         axis;
  logic signed [idfe_pkg::VALUE_W-1:0] value;
  logic [7:0]                         status_bits;
  logic                               last;

  modport source (output valid, output kind, output axis, output value,
                  output status_bits, output last, input ready);
  modport sink (input valid, input kind, input axis, input value,
                input status_bits, input last, output ready);
endinterface

interface idfe_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [idfe_pkg::CFG_IDX_W-1:0]    index;
  logic [idfe_pkg::GAIN_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/idfe_front.sv
// Front part of the extractor: accepts datagram bytes, tracks the section,
// assembles fields and pushes finished values into the queue. Uses idfe_pkg.
`default_nettype none

module idfe_front #(
  parameter int INERTIAL_BYTES = 3,
  parameter int TEMP_BYTES     = 2,
  parameter int AUX_BYTES      = 3,
  parameter int COUNTER_BYTES  = 1,
  parameter int LATENCY_BYTES  = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  idfe_in_if.sink                         byte_in,
  input  wire logic [idfe_pkg::MASK_W-1:0] include_mask,
  input  wire idfe_pkg::q_stat_t          q_stat,
  output logic                            push,
  output idfe_pkg::entry_t                push_entry
);
  import idfe_pkg::*;

  section_t         section, section_next;
  logic [1:0]       axis_count, axis_count_next;
  logic [1:0]       byte_count, byte_count_next;
  logic [RAW_W-1:0] assembly, assembly_next;
  logic [7:0]       status_acc, status_acc_next;

  logic             accept;
  logic [RAW_W-1:0] asm_in;
  logic [RAW_W-1:0] raw;
  logic [1:0]       width;
  logic [1:0]       bc_inc;

  assign byte_in.ready = !q_stat.full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_comb begin
    if (axis_count == STATUS_SLOT)      width = STATUS_BYTES;
    else if (section <= SEC_INCL)       width = 2'(INERTIAL_BYTES);
    else if (section <= SEC_INCL_TEMP)  width = 2'(TEMP_BYTES);
    else if (section == SEC_AUX)        width = 2'(AUX_BYTES);
    else if (section == SEC_COUNTER)    width = 2'(COUNTER_BYTES);
    else                                width = 2'(LATENCY_BYTES);
  end

  assign asm_in = {assembly[RAW_W-9:0], byte_in.data_byte};
  assign bc_inc = byte_count + 2'd1;

  always_comb begin
    case (width)
      2'd1:    raw = {16'd0, asm_in[7:0]};
      2'd2:    raw = {8'd0, asm_in[15:0]};
      default: raw = asm_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section    <= SEC_IDLE;
      axis_count <= 2'd0;
      byte_count <= 2'd0;
      assembly   <= '0;
      status_acc <= 8'd0;
    end else begin
      section    <= section_next;
      axis_count <= axis_count_next;
      byte_count <= byte_count_next;
      assembly   <= assembly_next;
      status_acc <= status_acc_next;
    end
  end

  always_comb begin
    section_next      = section;
    axis_count_next   = axis_count;
    byte_count_next   = byte_count;
    assembly_next     = assembly;
    status_acc_next   = status_acc;
    push              = 1'b0;
    push_entry.kind   = 4'(section) - 4'd1;
    push_entry.axis   = axis_count;
    push_entry.raw    = raw;
    push_entry.nbytes = width;
    push_entry.status = status_acc;
    push_entry.last   = 1'b0;
    if (accept) begin
      if (byte_in.frame_start) begin
        axis_count_next = 2'd0;
        byte_count_next = 2'd0;
        assembly_next   = '0;
        status_acc_next = 8'd0;
        section_next    = following(SEC_IDLE, include_mask);
      end else if (section != SEC_IDLE) begin
        if (bc_inc != width) begin
          byte_count_next = bc_inc;
          assembly_next   = asm_in;
        end else begin
          byte_count_next = 2'd0;
          assembly_next   = '0;
          if (axis_count == STATUS_SLOT) begin
            status_acc_next = status_acc | raw[7:0];
            axis_count_next = 2'd0;
            section_next    = following(section, include_mask);
          end else begin
            push = 1'b1;
            case (section)
              SEC_COUNTER: begin
                push_entry.axis = 2'd0;
                section_next    = SEC_LATENCY;
              end
              SEC_LATENCY: begin
                push_entry.axis = 2'd0;
                push_entry.last = 1'b1;
                section_next    = SEC_IDLE;
              end
              SEC_AUX: begin
                push_entry.axis = 2'd0;
                axis_count_next = STATUS_SLOT;
              end
              default: begin
                axis_count_next = axis_count + 2'd1;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idfe_queue.sv
// Short queue of finished field values between the front and back parts.
// Uses idfe_pkg for the entry type and depth.
`default_nettype none

module idfe_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire idfe_pkg::entry_t push_entry,
  input  wire logic             pop,
  output idfe_pkg::entry_t      head,
  output idfe_pkg::q_stat_t     q_stat
);
  import idfe_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idfe_back.sv
// Back part of the extractor: sign-extends queued fields, scales all but counter
// and latency by its gain in two partial-product stages, holds the result. Uses idfe_pkg.
`default_nettype none

module idfe_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire idfe_pkg::entry_t head,
  input  wire idfe_pkg::q_stat_t q_stat,
  input  wire idfe_pkg::gains_t gains,
  output logic                  pop,
  idfe_out_if.source            result_out
);
  import idfe_pkg::*;

  logic                    a_v;
  logic signed [PP_W-1:0]  a_lo;
  logic signed [PP_W-1:0]  a_hi;
  logic                    a_scaled;
  logic [RAW_W-1:0]        a_raw;
  logic [3:0]              a_kind;
  logic [1:0]              a_axis;
  logic [7:0]              a_status;
  logic                    a_last;

  logic                    o_v;
  logic signed [VALUE_W-1:0] o_value;
  logic [3:0]              o_kind;
  logic [1:0]              o_axis;
  logic [7:0]              o_status;
  logic                    o_last;

  logic                    adv_o;
  logic                    adv_a;
  logic signed [SX_W-1:0]  sx;
  logic [GAIN_W-1:0]       gain;
  logic signed [GAIN_SPLIT:0] g_lo;
  logic signed [GAIN_SPLIT:0] g_hi;
  logic signed [VALUE_W-1:0] scaled;

  assign adv_o = !o_v || result_out.ready;
  assign adv_a = !a_v || adv_o;
  assign pop   = adv_a && !q_stat.empty;

  always_comb begin
    case (head.nbytes)
      2'd1:    sx = {{(SX_W-8){head.raw[7]}}, head.raw[7:0]};
      2'd2:    sx = {{(SX_W-16){head.raw[15]}}, head.raw[15:0]};
      default: sx = {head.raw[RAW_W-1], head.raw};
    endcase
  end

  always_comb begin
    case (head.kind)
      KIND_GYRO:       gain = gains.gyro;
      KIND_ACCEL:      gain = gains.accel;
      KIND_INCL:       gain = gains.incline;
      KIND_GYRO_TEMP,
      KIND_ACCEL_TEMP,
      KIND_INCL_TEMP:  gain = gains.temperature;
      default:         gain = gains.aux;
    endcase
  end

  assign g_lo = {1'b0, gain[GAIN_SPLIT-1:0]};
  assign g_hi = {1'b0, gain[GAIN_W-1:GAIN_SPLIT]};

  assign scaled = VALUE_W'(a_lo) + (VALUE_W'(a_hi) <<< GAIN_SPLIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (adv_a) a_v <= !q_stat.empty;
      if (adv_o) o_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_lo     <= sx * g_lo;
      a_hi     <= sx * g_hi;
      a_scaled <= (head.kind <= KIND_AUX);
      a_raw    <= head.raw;
      a_kind   <= head.kind;
      a_axis   <= head.axis;
      a_status <= head.status;
      a_last   <= head.last;
    end
    if (adv_o) begin
      o_value  <= a_scaled ? scaled : {{(VALUE_W-RAW_W){1'b0}}, a_raw};
      o_kind   <= a_kind;
      o_axis   <= a_axis;
      o_status <= a_status;
      o_last   <= a_last;
    end
  end

  assign result_out.valid       = o_v;
  assign result_out.kind        = o_kind;
  assign result_out.axis        = o_axis;
  assign result_out.value       = o_value;
  assign result_out.status_bits = o_status;
  assign result_out.last        = o_last;

endmodule

`default_nettype wire

FILE: rtl/imu_datagram_field_extractor.sv
// IMU datagram field extractor, top level. Takes one datagram byte per cycle
// while byte_in.ready is high and returns one item per finished field value.
// Depends on idfe_pkg, idfe_if, idfe_front, idfe_queue and idfe_back.
//
// The block accepts one byte per clock cycle, sustained, as long as results are
// taken at the same pace. A byte marked frame_start is the identifier byte; it
// is skipped and restarts parsing, clearing the status accumulator. Sections
// follow in fixed order (gyro, accel, inclinometer triples, their temperature
// triples, aux, counter, latency), each sensor section gated by include_mask
// and followed by one status byte that is ORed into status_bits. Fields are
// big-endian. The front parser classifies each byte in the cycle it arrives
// and writes finished values into a four-entry queue; the back part
// sign-extends a queued value, multiplies it by its 40-bit gain as two
// partial products of its 20-bit halves in one stage and sums them into
// the output register, which holds the item. A finished value passes through
// the queue, the partial-product register and the output register before it
// is offered at the output, and the queue absorbs output stalls until it
// fills, when byte_in.ready drops. Counter and latency values pass
// unscaled; latency carries last. Configuration writes are always ready and
// take effect in the next cycle; they are meant to be made while no frame is
// being parsed and no result is pending.
`default_nettype none

module imu_datagram_field_extractor #(
  parameter int INERTIAL_BYTES = 3,
  parameter int TEMP_BYTES     = 2,
  parameter int AUX_BYTES      = 3,
  parameter int COUNTER_BYTES  = 1,
  parameter int LATENCY_BYTES  = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  idfe_in_if.sink     byte_in,
  idfe_out_if.source  result_out,
  idfe_cfg_if.sink    cfg
);
  import idfe_pkg::*;

  logic [MASK_W-1:0] include_mask;
  gains_t            gains;
  logic              push;
  entry_t            push_entry;
  logic              pop;
  entry_t            head;
  q_stat_t           q_stat;

  // Configuration registers. Writes to an index past the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      include_mask <= MASK_RESET;
      gains        <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_INCLUDE_MASK:     include_mask      <= cfg.data[MASK_W-1:0];
        CFG_GYRO_GAIN:        gains.gyro        <= cfg.data;
        CFG_ACCEL_GAIN:       gains.accel       <= cfg.data;
        CFG_INCLINE_GAIN:     gains.incline     <= cfg.data;
        CFG_TEMPERATURE_GAIN: gains.temperature <= cfg.data;
        CFG_AUX_GAIN:         gains.aux         <= cfg.data;
        default:              ;
      endcase
    end
  end

  // The parser reads the mask at frame start and when each section with a status byte ends.
  idfe_front #(
    .INERTIAL_BYTES (INERTIAL_BYTES),
    .TEMP_BYTES     (TEMP_BYTES),
    .AUX_BYTES      (AUX_BYTES),
    .COUNTER_BYTES  (COUNTER_BYTES),
    .LATENCY_BYTES  (LATENCY_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_in),
    .include_mask (include_mask),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Finished values wait here so that the parser does not wait on the scaler until the queue is full.
  idfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Gains are read when an entry leaves the queue.
  idfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .gains      (gains),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

FILE: rtl/idfe_checker.sv
// Port-level checker for the IMU datagram field extractor, with the bind that
// attaches it to the top level. Uses idfe_pkg for kind codes.
`default_nettype none

module idfe_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [3:0]                 out_kind,
  input wire logic [1:0]                 out_axis,
  input wire logic [idfe_pkg::VALUE_W-1:0] out_value,
  input wire logic                       out_last,
  input wire logic                       cfg_ready
);
  import idfe_pkg::*;

  // Only the latency item closes a frame.
  a_last_is_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_kind == KIND_LATENCY)
    else $error("last set on a non-latency item");

  a_latency_has_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_LATENCY) |-> out_last)
    else $error("latency item without last");

  // Single fields always report axis zero.
  a_single_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_AUX || out_kind == KIND_COUNTER ||
                  out_kind == KIND_LATENCY) |-> out_axis == 2'd0)
    else $error("nonzero axis on a single field");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind imu_datagram_field_extractor idfe_checker u_idfe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_kind  (result_out.kind),
  .out_axis  (result_out.axis),
  .out_value (result_out.value),
  .out_last  (result_out.last),
  .cfg_ready (cfg.ready)
);

`default_nettype wire
